// ===== hw/rtl/epi_pkg.sv =====
// ----------------------------------------------------------------------------
// epi_pkg: shared types and constants of the palette indexer
// Opcodes, controller states, chain token and broadcast bundles.
// ----------------------------------------------------------------------------
package epi_pkg;

  localparam int PaletteCapacity = 256;  // 16 .. 256
  localparam int TableDepth      = 256;
  localparam int NumCells        = (PaletteCapacity > TableDepth) ? TableDepth
                                                                  : PaletteCapacity;
  localparam int NibbleCapacity  = 16;
  localparam int ColorW          = 32;
  localparam int IdxW            = 8;
  localparam int CountW          = 9;
  localparam int NibW            = 4;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpLearn = 2'd1,
    OpMap   = 2'd2,
    OpRead  = 2'd3
  } epi_op_e;

  typedef enum logic {
    StIdle = 1'b0,
    StWalk = 1'b1
  } epi_state_e;

  // token handed from cell to cell; payload holds the stored flag (learn),
  // the matching index (map) or the entry read (read)
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [ColorW-1:0] payload;
  } epi_tok_t;

  // command held steady for every cell while a token walks the chain
  typedef struct packed {
    epi_op_e           op;
    logic [ColorW-1:0] color;
    logic [IdxW-1:0]   sel;
    logic [CountW-1:0] count;
    logic              nibble;
    logic              clear;
  } epi_bcast_t;

endpackage

// ===== hw/rtl/exact_color_palette_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// exact_color_palette_indexer_unit: exact-colour palette builder and indexer
// Chain of palette cells walked by one command token, plus the controller.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands: drive opcode_i, pixel_color_i and entry_select_i with start;
//    the transaction is taken on a clock edge where start is high and busy
//    is low. Clear completes at that edge and busy stays low.
//  - Learn, map and read launch a token into the cell chain; it advances one
//    cell per cycle, and every such command keeps busy high until the token
//    leaves the last cell; the next command can only follow after that.
//  - Map and read results are registered as the token leaves the chain, for a
//    single cycle, flagged by result_valid_o. The receiver cannot stall, so
//    there is no back-pressure path. In 4-bit mode the first map of a pair
//    gives no result; the second emits the packed byte.
//  - Configuration: cfg_valid_i/cfg_ready_o write nibble_mode; ready is low
//    while a command is in the chain. A write drops any half-built byte.
//  - Reset (rst_ni low, asynchronous) empties the palette, clears counters,
//    flags and nibble_mode at once; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module exact_color_palette_indexer_unit import epi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command transaction
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [ColorW-1:0] pixel_color_i,
  input  logic [IdxW-1:0]   entry_select_i,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_nibble_mode_i,
  // result
  output logic              result_valid_o,
  output logic              result_kind_o,
  output logic [IdxW-1:0]   index_byte_o,
  output logic [ColorW-1:0] entry_color_o,
  output logic [CountW-1:0] color_count_o,
  output logic              overflowed_o
);

  epi_state_e        state_q, state_d;
  epi_op_e           in_op;
  logic              accept;
  logic              clear_now;
  logic              launch_d;
  logic              finish;

  // command held during the walk
  epi_op_e           op_q;
  logic [ColorW-1:0] color_q;
  logic [IdxW-1:0]   sel_q;
  logic              launch_q;

  // architectural state outside the cells
  logic              nibble_q;
  logic [CountW-1:0] count_q;
  logic              ovf_q;
  logic [NibW-1:0]   pend_q;
  logic              half_q;

  // result registers
  logic              res_valid_q;
  logic              res_kind_q;
  logic [IdxW-1:0]   res_byte_q;
  logic [ColorW-1:0] res_color_q;

  epi_bcast_t        bcast;
  epi_tok_t          tok [NumCells+1];
  epi_tok_t          tail;
  logic [IdxW-1:0]   found_idx;
  logic              cfg_write;

  assign in_op     = epi_op_e'(opcode_i);
  assign busy      = (state_q == StWalk);
  assign accept    = start && !busy;
  assign clear_now = accept && (in_op == OpClear);
  assign launch_d  = accept && (in_op != OpClear);
  assign cfg_ready_o = !busy;
  assign cfg_write = cfg_valid_i && cfg_ready_o;

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (launch_d) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // command capture; payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      color_q <= pixel_color_i;
      sel_q   <= entry_select_i;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: token enters cell 0 the cycle after acceptance
  // --------------------------------------------------------------------------
  assign bcast.op     = op_q;
  assign bcast.color  = color_q;
  assign bcast.sel    = sel_q;
  assign bcast.count  = count_q;
  assign bcast.nibble = nibble_q;
  assign bcast.clear  = clear_now;

  assign tok[0].active  = launch_q;
  assign tok[0].hit     = 1'b0;
  assign tok[0].payload = '0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    epi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(k)),
      .bcast_i    (bcast),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  assign tail      = tok[NumCells];
  assign finish    = tail.active;
  // no match leaves the payload at zero, which is index 0
  assign found_idx = tail.payload[IdxW-1:0];

  // --------------------------------------------------------------------------
  // Control state, counters and flags
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q    <= 1'b0;
      nibble_q    <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= '0;
      half_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      launch_q    <= launch_d;
      res_valid_q <= 1'b0;
      if (clear_now) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        pend_q  <= '0;
        half_q  <= 1'b0;
      end
      if (cfg_write) begin
        nibble_q <= cfg_nibble_mode_i;
        pend_q   <= '0;
        half_q   <= 1'b0;
      end
      if (finish) begin
        case (op_q)
          OpLearn: begin
            if (!tail.hit) begin
              ovf_q <= 1'b1;               // new colour, table full
            end else if (tail.payload[0]) begin
              count_q <= count_q + CountW'(1);
            end
          end
          OpMap: begin
            if (!nibble_q) begin
              res_valid_q <= 1'b1;
            end else if (!half_q) begin
              pend_q <= found_idx[NibW-1:0];
              half_q <= 1'b1;
            end else begin
              pend_q      <= '0;
              half_q      <= 1'b0;
              res_valid_q <= 1'b1;
            end
          end
          OpRead: res_valid_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_kind_q  <= (op_q == OpRead);
      res_byte_q  <= '0;
      res_color_q <= '0;
      if (op_q == OpRead) begin
        res_color_q <= tail.payload;
      end else if (nibble_q) begin
        res_byte_q <= {found_idx[NibW-1:0], pend_q};
      end else begin
        res_byte_q <= found_idx;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign index_byte_o   = res_byte_q;
  assign entry_color_o  = res_color_q;
  // counters only change on learn/clear, so the live values match the result
  assign color_count_o  = count_q;
  assign overflowed_o   = ovf_q;

endmodule

// ===== hw/rtl/epi_cell.sv =====
// ----------------------------------------------------------------------------
// epi_cell: one palette entry of the chain
// Holds one colour, matches it to the broadcast colour and forwards the token.
// ----------------------------------------------------------------------------
module epi_cell import epi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] cell_idx_i,
  input  epi_bcast_t      bcast_i,
  input  epi_tok_t        tok_i,
  output epi_tok_t        tok_o
);

  logic [ColorW-1:0] entry_q, entry_d;
  epi_tok_t          tok_q, tok_d;
  logic              match;
  logic              below_count;
  logic              at_count;
  logic              in_range;

  assign match       = (entry_q == bcast_i.color);
  assign below_count = ({1'b0, cell_idx_i} < bcast_i.count);
  assign at_count    = ({1'b0, cell_idx_i} == bcast_i.count);
  assign in_range    = !bcast_i.nibble || (cell_idx_i < IdxW'(NibbleCapacity));

  always_comb begin
    entry_d = entry_q;
    tok_d   = tok_i;
    if (tok_i.active) begin
      case (bcast_i.op)
        OpLearn: begin
          if (!tok_i.hit) begin
            if (below_count && match) begin
              tok_d.hit = 1'b1;
            end else if (at_count && in_range) begin
              entry_d       = bcast_i.color;
              tok_d.hit     = 1'b1;
              tok_d.payload = ColorW'(1);  // stored flag
            end
          end
        end
        OpMap: begin
          if (!tok_i.hit && in_range && match) begin
            tok_d.hit     = 1'b1;
            tok_d.payload = ColorW'(cell_idx_i);
          end
        end
        OpRead: begin
          if (cell_idx_i == bcast_i.sel) begin
            tok_d.payload = entry_q;
          end
        end
        default: ;
      endcase
    end
    if (bcast_i.clear) begin
      entry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/epi_checker.sv =====
// ----------------------------------------------------------------------------
// epi_checker: port-level checks for the palette indexer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module epi_checker import epi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [1:0]        opcode_i,
  input logic              result_valid_o,
  input logic              result_kind_o,
  input logic [ColorW-1:0] entry_color_o,
  input logic [CountW-1:0] color_count_o
);

  // a walking command always occupies the block on the next cycle
  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (epi_op_e'(opcode_i) != OpClear) |=> busy)
    else $error("command accepted but block not busy");

  // results come out as the walk ends, never mid-walk
  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result outside end of walk");

  // strobe is a single-cycle pulse
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // map results carry no entry colour
  a_map_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_kind_o |-> entry_color_o == '0)
    else $error("map result with non-zero entry colour");

  // colour count never passes the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_count_o <= CountW'(NumCells))
    else $error("colour count beyond capacity");

endmodule

bind exact_color_palette_indexer_unit epi_checker u_epi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .entry_color_o  (entry_color_o),
  .color_count_o  (color_count_o)
);

// ===== tb/epi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epi_scoreboard: palette indexer result predictor and comparator
// Watches command, mode-write and result transactions, keeps a shadow palette
// and checks every result against the oldest one owed.
// ----------------------------------------------------------------------------
module epi_scoreboard import epi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [ColorW-1:0] pixel_color_i,
  input  logic [IdxW-1:0]   entry_select_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic              cfg_nibble_mode_i,
  input  logic              result_valid_o,
  input  logic              result_kind_o,
  input  logic [IdxW-1:0]   index_byte_o,
  input  logic [ColorW-1:0] entry_color_o,
  input  logic [CountW-1:0] color_count_o,
  input  logic              overflowed_o,
  output int                mismatch_count,
  output int                results_owed,
  output int                results_checked
);

  typedef struct packed {
    logic              kind;
    logic [IdxW-1:0]   idx_byte;
    logic [ColorW-1:0] colour;
    logic [CountW-1:0] count;
    logic              ovf;
  } pal_result_t;

  logic [ColorW-1:0] shadow_pal [TableDepth];
  logic [CountW-1:0] shadow_count;
  logic              shadow_ovf;
  logic [NibW-1:0]   low_nibble;
  logic              second_half;
  logic              nibble_mode;
  pal_result_t       owed_q [$];

  initial begin
    mismatch_count  = 0;
    results_owed    = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [ColorW-1:0] got,
                             input logic [ColorW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  task automatic wipe_palette();
    for (int i = 0; i < TableDepth; i++) shadow_pal[i] = '0;
    shadow_count = '0;
    shadow_ovf   = 1'b0;
    low_nibble   = '0;
    second_half  = 1'b0;
  endtask

  function automatic int unsigned live_capacity();
    return nibble_mode ? NibbleCapacity : NumCells;
  endfunction

  // search spans every live slot, unused ones included (they hold zero)
  function automatic int unsigned first_hit(input logic [ColorW-1:0] c);
    for (int unsigned i = 0; i < live_capacity(); i++) begin
      if (shadow_pal[i] == c) return i;
    end
    return 0;
  endfunction

  task automatic learn_colour(input logic [ColorW-1:0] c);
    int unsigned lim;
    bit          seen;
    lim  = (shadow_count < TableDepth) ? shadow_count : TableDepth;
    seen = 1'b0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (shadow_pal[i] == c) seen = 1'b1;
    end
    if (!seen) begin
      // count may exceed 16 after a switch to nibble mode: treated as full
      if (shadow_count >= live_capacity()) begin
        shadow_ovf = 1'b1;
      end else begin
        shadow_pal[shadow_count[IdxW-1:0]] = c;
        shadow_count = shadow_count + 1'b1;
      end
    end
  endtask

  task automatic predict(input epi_op_e op, input logic [ColorW-1:0] c,
                         input logic [IdxW-1:0] sel);
    pal_result_t     r;
    logic [IdxW-1:0] hit;
    bit              emits;
    r     = '0;
    emits = 1'b0;
    case (op)
      OpClear: wipe_palette();
      OpLearn: learn_colour(c);
      OpMap: begin
        hit = IdxW'(first_hit(c));
        if (!nibble_mode) begin
          r.idx_byte = hit;
          emits      = 1'b1;
        end else if (!second_half) begin
          low_nibble  = hit[NibW-1:0];
          second_half = 1'b1;
        end else begin
          r.idx_byte  = {hit[NibW-1:0], low_nibble};
          low_nibble  = '0;
          second_half = 1'b0;
          emits       = 1'b1;
        end
      end
      OpRead: begin
        r.kind   = 1'b1;
        r.colour = shadow_pal[sel];
        emits    = 1'b1;
      end
      default: ;
    endcase
    if (emits) begin
      r.count = shadow_count;
      r.ovf   = shadow_ovf;
      owed_q  = {owed_q, r};
    end
  endtask

  task automatic check_result();
    pal_result_t want;
    if (owed_q.size() == 0) begin
      report_mismatch("result with none owed");
    end else begin
      want = owed_q.pop_front();
      check_field("result_kind", ColorW'(result_kind_o), ColorW'(want.kind));
      check_field("index_byte", ColorW'(index_byte_o), ColorW'(want.idx_byte));
      check_field("entry_color", entry_color_o, want.colour);
      check_field("color_count", ColorW'(color_count_o), ColorW'(want.count));
      check_field("overflowed", ColorW'(overflowed_o), ColorW'(want.ovf));
      results_checked++;
    end
  endtask

  // order within an edge: retire a result, then mode write, then new command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_palette();
      nibble_mode = 1'b0;
      owed_q.delete();
      results_owed = 0;
    end else begin
      if (result_valid_o) check_result();
      if (cfg_valid_i && cfg_ready_o) begin
        nibble_mode = cfg_nibble_mode_i;
        low_nibble  = '0;
        second_half = 1'b0;
      end
      if (start && !busy) predict(epi_op_e'(opcode_i), pixel_color_i, entry_select_i);
      results_owed = owed_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: palette indexer testbench top
// Drives command and mode-write transactions through directed and random
// phases with varying sender gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import epi_pkg::*;

  // learn, map and read walk the whole chain; allow for that plus some slack
  localparam int SettleCycles = NumCells + 4;
  localparam int QuietLimit   = 8 * NumCells + 256;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              start             = 1'b0;
  logic [1:0]        opcode_i          = '0;
  logic [ColorW-1:0] pixel_color_i     = '0;
  logic [IdxW-1:0]   entry_select_i    = '0;
  logic              cfg_valid_i       = 1'b0;
  logic              cfg_nibble_mode_i = 1'b0;

  logic              busy;
  logic              cfg_ready_o;
  logic              result_valid_o;
  logic              result_kind_o;
  logic [IdxW-1:0]   index_byte_o;
  logic [ColorW-1:0] entry_color_o;
  logic [CountW-1:0] color_count_o;
  logic              overflowed_o;

  int                mismatch_count;
  int                results_owed;
  int                results_checked;

  int                sender_idle_pct = 0;
  int                ops_sent [4]    = '{0, 0, 0, 0};
  int                mode_writes     = 0;
  int                quiet_cycles    = 0;
  logic [ColorW-1:0] colour_pool [$];

  // sender gap per random phase: none, heavy, none (receiver slot), moderate.
  // The receiver cannot hold results off, so its stall settings have no effect.
  int                idle_table [4]  = '{0, 69, 0, 37};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  exact_color_palette_indexer_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .pixel_color_i     (pixel_color_i),
    .entry_select_i    (entry_select_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_nibble_mode_i (cfg_nibble_mode_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .index_byte_o      (index_byte_o),
    .entry_color_o     (entry_color_o),
    .color_count_o     (color_count_o),
    .overflowed_o      (overflowed_o)
  );

  epi_scoreboard checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .pixel_color_i     (pixel_color_i),
    .entry_select_i    (entry_select_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_nibble_mode_i (cfg_nibble_mode_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .index_byte_o      (index_byte_o),
    .entry_color_o     (entry_color_o),
    .color_count_o     (color_count_o),
    .overflowed_o      (overflowed_o),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed),
    .results_checked   (results_checked)
  );

  // watchdog: any transaction (command, mode write or result) rearms it
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transaction for %0d cycles", QuietLimit);
      $display("exact_color_palette_indexer_unit test failed");
      $finish;
    end
  end

  // one command transaction; start is left high after acceptance so that a
  // following command can go straight on at the next falling edge
  task automatic send_cmd(input epi_op_e op, input logic [ColorW-1:0] colour,
                          input logic [IdxW-1:0] sel);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    pixel_color_i  <= colour;
    entry_select_i <= sel;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ops_sent[int'(op)]++;
  endtask

  // sender holds off until every owed result has been seen
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  // mode write only on an idle block; a lone first nibble may still be walking
  task automatic write_mode(input logic mode);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_nibble_mode_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_writes++;
  endtask

  task automatic random_phase(input int items, input logic mode);
    int                n_learn;
    int                pick;
    logic [ColorW-1:0] c;
    write_mode(mode);
    if ($urandom_range(0, 3) != 0) begin
      send_cmd(OpClear, $urandom(), IdxW'($urandom()));
      colour_pool.delete();
      items--;
    end
    // mostly a well-formed build-up first, so maps and reads have hits to find
    n_learn = mode ? $urandom_range(4, 18) : $urandom_range(4, 24);
    for (int i = 0; i < n_learn; i++) begin
      c = $urandom();
      colour_pool = {colour_pool, c};
      send_cmd(OpLearn, c, IdxW'($urandom()));
    end
    for (int i = n_learn; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && colour_pool.size() != 0) begin
          c = colour_pool[$urandom_range(0, colour_pool.size() - 1)];
        end else if (pick < 85) begin
          c = '0;
        end else begin
          c = $urandom();
        end
        send_cmd(OpMap, c, IdxW'($urandom()));
      end else if (pick < 75) begin
        send_cmd(OpRead, $urandom(),
                 ($urandom_range(0, 9) < 7) ? IdxW'($urandom_range(0, 24))
                                            : IdxW'($urandom()));
      end else if (pick < 95) begin
        if ($urandom_range(0, 1) && colour_pool.size() != 0) begin
          c = colour_pool[$urandom_range(0, colour_pool.size() - 1)];
        end else begin
          c = $urandom();
          colour_pool = {colour_pool, c};
        end
        send_cmd(OpLearn, c, IdxW'($urandom()));
      end else begin
        send_cmd(OpClear, $urandom(), IdxW'($urandom()));
        colour_pool.delete();
      end
    end
  endtask

  initial begin
    logic [ColorW-1:0] first_c;
    logic [ColorW-1:0] last_c;
    logic [ColorW-1:0] c;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, byte mode straight from reset: empty table, duplicates,
    // extreme colours, zero matching an unused slot
    sender_idle_pct = 0;
    send_cmd(OpRead,  32'h0,        8'd0);
    send_cmd(OpRead,  32'h0,        8'd255);
    send_cmd(OpMap,   32'h0000_0000, 8'd0);
    send_cmd(OpMap,   32'hFFFF_FFFF, 8'hFF);
    send_cmd(OpLearn, 32'hFFFF_FFFF, 8'd0);
    send_cmd(OpLearn, 32'h0000_0000, 8'd0);
    send_cmd(OpLearn, 32'hFFFF_FFFF, 8'd0);
    send_cmd(OpLearn, 32'h1234_5678, 8'd0);
    send_cmd(OpMap,   32'h1234_5678, 8'd0);
    send_cmd(OpMap,   32'h0000_0000, 8'd0);
    send_cmd(OpMap,   32'hFFFF_FFFF, 8'd0);
    send_cmd(OpMap,   32'hDEAD_BEEF, 8'd0);
    for (int i = 0; i < 4; i++) send_cmd(OpRead, 32'h0, IdxW'(i));
    send_cmd(OpClear, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(OpRead,  32'h0,        8'd0);
    send_cmd(OpMap,   32'h0000_0000, 8'd0);

    // nibble mode: fill all 16 slots, overflow, pack both nibble extremes,
    // odd pixel dropped by a mode write and by a clear
    sender_idle_pct = 69;
    write_mode(1'b1);
    send_cmd(OpClear, 32'h0, 8'd0);
    for (int i = 0; i < 16; i++) send_cmd(OpLearn, 32'hA5A5_0000 + i, 8'd0);
    send_cmd(OpLearn, 32'hA5A5_0003, 8'd0);
    send_cmd(OpLearn, 32'h5A5A_5A5A, 8'd0);
    send_cmd(OpMap,   32'hA5A5_000F, 8'd0);
    send_cmd(OpMap,   32'hA5A5_0000, 8'd0);
    send_cmd(OpMap,   32'hA5A5_0000, 8'd0);
    send_cmd(OpMap,   32'hA5A5_000F, 8'd0);
    send_cmd(OpRead,  32'h0, 8'd15);
    send_cmd(OpRead,  32'h0, 8'd16);
    send_cmd(OpRead,  32'h0, 8'd255);
    send_cmd(OpMap,   32'hA5A5_0007, 8'd0);
    write_mode(1'b1);
    send_cmd(OpMap,   32'hA5A5_0001, 8'd0);
    send_cmd(OpMap,   32'hA5A5_0002, 8'd0);
    send_cmd(OpMap,   32'hA5A5_0005, 8'd0);
    send_cmd(OpClear, 32'h0, 8'd0);
    send_cmd(OpMap,   32'h0, 8'd0);
    send_cmd(OpMap,   32'h0, 8'd0);

    // count above 16 carried into nibble mode: learn sees a full table and
    // map only looks at the first 16 slots
    sender_idle_pct = 37;
    write_mode(1'b0);
    send_cmd(OpClear, 32'h0, 8'd0);
    for (int i = 0; i < 20; i++) send_cmd(OpLearn, 32'h3C00_0000 + i, 8'd0);
    write_mode(1'b1);
    send_cmd(OpLearn, 32'h3CFF_FFFF, 8'd0);
    send_cmd(OpLearn, 32'h3C00_0013, 8'd0);
    send_cmd(OpMap,   32'h3C00_0012, 8'd0);
    send_cmd(OpMap,   32'h3C00_0003, 8'd0);
    send_cmd(OpRead,  32'h0, 8'd19);

    // full byte-mode table: 256 distinct colours, then overflow and top index
    sender_idle_pct = 0;
    write_mode(1'b0);
    send_cmd(OpClear, 32'h0, 8'd0);
    colour_pool.delete();
    for (int i = 0; i < 256; i++) begin
      c = {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(i)};
      c = {c[7:0], c[31:8]};
      colour_pool = {colour_pool, c};
      send_cmd(OpLearn, c, IdxW'($urandom()));
    end
    first_c = colour_pool[0];
    last_c  = colour_pool[255];
    send_cmd(OpLearn, ~last_c, 8'd0);
    send_cmd(OpLearn, first_c, 8'd0);
    send_cmd(OpMap,   last_c, 8'd0);
    send_cmd(OpMap,   first_c, 8'd0);
    send_cmd(OpMap,   colour_pool[128], 8'd0);
    send_cmd(OpMap,   ~last_c, 8'd0);
    send_cmd(OpRead,  32'h0, 8'd255);
    send_cmd(OpRead,  32'h0, 8'd128);

    for (int p = 0; p < 7; p++) begin
      sender_idle_pct = idle_table[p % 4];
      random_phase(32, (p < 2) ? logic'(p) : logic'($urandom_range(0, 1)));
    end

    drain();
    repeat (SettleCycles) @(negedge clk_i);

    $display("Commands: %0d clear, %0d learn, %0d map, %0d read; %0d mode writes",
             ops_sent[OpClear], ops_sent[OpLearn], ops_sent[OpMap], ops_sent[OpRead],
             mode_writes);
    $display("Results compared: %0d, mismatches: %0d", results_checked, mismatch_count);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("exact_color_palette_indexer_unit test passed");
    end else begin
      $display("exact_color_palette_indexer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/epi_pkg.sv
hw/rtl/epi_cell.sv
hw/rtl/exact_color_palette_indexer_unit.sv
hw/rtl/epi_checker.sv
tb/epi_checker.sv
tb/tb.sv
